// ----- rtl/core/rgb2yuv_pkg.sv -----
// Shared types and constants for the RGB to BT.709 4:2:0 YCbCr converter.
// Used by the converter top level and its port checker; no dependencies.
`default_nettype none

package rgb2yuv_pkg;

	// Configuration port geometry
	localparam int CFG_DATA_W  = 14;
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	// Frame size limits and reset values
	localparam int ROW_W = 13;
	localparam logic [CFG_DATA_W:0]   MAX_HEIGHT = 15'd8192;
	localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 14'd16;
	localparam logic [CFG_DATA_W-1:0] SIZE_MIN   = 14'd2;

	// Luma coefficients (scaled by 10000)
	localparam logic [12:0] Y_R = 13'd1826;
	localparam logic [12:0] Y_G = 13'd6142;
	localparam logic [12:0] Y_B = 13'd620;
	localparam logic [12:0] ROUND_BIAS = 13'd5000;
	localparam logic [7:0]  LUMA_OFS = 8'd16;

	// Chroma coefficients (scaled by 10000)
	localparam logic signed [13:0] CB_R = -14'sd1006;
	localparam logic signed [13:0] CB_G = -14'sd3386;
	localparam logic signed [13:0] CB_B = 14'sd4392;
	localparam logic signed [13:0] CR_R = 14'sd4392;
	localparam logic signed [13:0] CR_G = -14'sd3989;
	localparam logic signed [13:0] CR_B = -14'sd403;
	localparam logic signed [13:0] ROUND_BIAS_S = 14'sd5000;
	localparam logic [7:0] CHROMA_OFS = 8'd128;

	// Divide by 10000: q = (n * RECIP_M) >> RECIP_SHIFT, exact for n < 2^22
	localparam logic [22:0] RECIP_M = 23'd6871948;
	localparam int RECIP_SHIFT = 36;

	typedef enum logic {
		KIND_LUMA   = 1'b0,
		KIND_CHROMA = 1'b1
	} kind_t;

	// Per-pixel control carried down the pipeline
	typedef struct packed {
		logic chroma;
		logic frame_end;
	} pix_flags_t;

	// Even size, raised to 2, capped at an even value not above cap
	function automatic logic [CFG_DATA_W-1:0] eff_size(
		input logic [CFG_DATA_W-1:0] raw,
		input logic [CFG_DATA_W:0]   cap
	);
		logic [CFG_DATA_W-1:0] even;
		even = {raw[CFG_DATA_W-1:1], 1'b0};
		if (even < SIZE_MIN) begin
			eff_size = SIZE_MIN;
		end else if ({1'b0, even} > cap) begin
			eff_size = {cap[CFG_DATA_W-1:1], 1'b0};
		end else begin
			eff_size = even;
		end
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rgba_to_i420_bt709_converter.sv -----
// RGB pixel stream to BT.709 limited-range 4:2:0 YCbCr, luma per pixel and
// chroma per 2x2 block. Depends on rgb2yuv_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall) takes one RGB pixel per item in raster
//   order. Output channel (out_valid/out_stall) gives a luma item for every
//   pixel; at the odd column of each odd row a chroma item follows it.
//   Frame size is set on the cfg port; the user must write it only while
//   the block is idle, as the block itself does not enforce this. A write
//   also restarts the frame at column 0, row 0.
// Throughput: 1 pixel per cycle while out_stall is low; an odd-row, odd-column
//   pixel holds stage 4 for two items, as the output moves one item per cycle.
// Line memory: MAX_WIDTH/2 entries of 27 bits holding the horizontal pair sums
//   of the even row; written on the even row, read one row later, read data
//   registered. It needs no clearing pass after reset.
// Reset: counters return to 0, frame size to 16x16, pipeline empties.
// Stall: a stalled output holds its item; stages behind it fill any bubbles
//   and then stall the input.
`default_nettype none

module rgba_to_i420_bt709_converter #(
	parameter int MAX_WIDTH = 8192
) (
	input  wire logic clk,
	input  wire logic arst_n,
	// configuration
	input  wire logic                                cfg_write,
	input  wire logic [rgb2yuv_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [rgb2yuv_pkg::CFG_DATA_W-1:0]  cfg_data,
	// pixel input
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	// result output
	output logic       out_valid,
	input  wire logic  out_stall,
	output logic       kind,
	output logic [7:0] luma,
	output logic [7:0] chroma_blue,
	output logic [7:0] chroma_red,
	output logic       last,
	output logic       frame_end
);

	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int ADDR_W     = $clog2(LINE_DEPTH);
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int DW         = rgb2yuv_pkg::CFG_DATA_W;
	localparam int RW         = rgb2yuv_pkg::ROW_W;

	// Configuration and raster position
	logic [DW-1:0]    width_q, height_q;
	logic [COL_W-1:0] col_q;
	logic [RW-1:0]    row_q;
	logic [23:0]      held_q;

	// Pipeline control
	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic in_acc, out_acc;
	logic phase_q;

	// Stage payloads
	rgb2yuv_pkg::pix_flags_t flags_s1, flags_s2, flags_s3, flags_s4;
	logic [7:0]  r_s1, g_s1, b_s1;
	logic [23:0] held_s1;
	logic [26:0] line_rd_s1;
	logic [21:0] luma_num_s2;
	logic [7:0]  ar_s2, ag_s2, ab_s2;
	logic [7:0]  yq_s3;
	logic [20:0] u_mag_s3, v_mag_s3;
	logic        u_neg_s3, v_neg_s3;
	logic [7:0]  y_s4, cb_s4, cr_s4;

	logic [26:0] line_mem [LINE_DEPTH];

	// Position decode for the incoming pixel
	logic              odd_col, odd_row, row_end, last_pix;
	logic [ADDR_W-1:0] line_addr;
	logic [8:0]        pair_r, pair_g, pair_b;

	assign odd_col   = col_q[0];
	assign odd_row   = row_q[0];
	assign row_end   = ((DW+1)'(col_q) + (DW+1)'(1)) >= {1'b0, width_q};
	assign last_pix  = row_end && (((DW+1)'(row_q) + (DW+1)'(1)) >= {1'b0, height_q});
	assign line_addr = col_q[ADDR_W:1];
	assign pair_r    = {1'b0, held_q[23:16]} + {1'b0, red};
	assign pair_g    = {1'b0, held_q[15:8]} + {1'b0, green};
	assign pair_b    = {1'b0, held_q[7:0]} + {1'b0, blue};

	// Handshake: each stage moves when the next one is free or moving
	assign rdy4     = !v4_s4 || (!out_stall && (!flags_s4.chroma || phase_q));
	assign rdy3     = !v3_s3 || rdy4;
	assign rdy2     = !v2_s2 || rdy3;
	assign rdy1     = !v1_s1 || rdy2;
	assign in_stall = !rdy1;
	assign in_acc   = in_valid && rdy1;
	assign out_acc  = out_valid && !out_stall;

	// Configuration, counters and held pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rgb2yuv_pkg::SIZE_RESET;
			height_q <= rgb2yuv_pkg::SIZE_RESET;
			col_q    <= '0;
			row_q    <= '0;
			held_q   <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				rgb2yuv_pkg::REG_FRAME_WIDTH: begin
					width_q <= rgb2yuv_pkg::eff_size(cfg_data, (DW+1)'(MAX_WIDTH));
					col_q   <= '0;
					row_q   <= '0;
				end
				rgb2yuv_pkg::REG_FRAME_HEIGHT: begin
					height_q <= rgb2yuv_pkg::eff_size(cfg_data, rgb2yuv_pkg::MAX_HEIGHT);
					col_q    <= '0;
					row_q    <= '0;
				end
				default: begin
				end
			endcase
		end else if (in_acc) begin
			if (!odd_col) begin
				held_q <= {red, green, blue};
			end
			if (row_end) begin
				col_q <= '0;
				row_q <= last_pix ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Line memory: write pair sums on even rows, read them on odd rows.
	// Write and read of one entry are a full row apart, so they never overlap.
	always_ff @(posedge clk) begin
		if (in_acc && odd_col && !odd_row) begin
			line_mem[line_addr] <= {pair_r, pair_g, pair_b};
		end
		if (in_acc && odd_col && odd_row) begin
			line_rd_s1 <= line_mem[line_addr];
		end
	end

	// Valid bits and output phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1   <= 1'b0;
			v2_s2   <= 1'b0;
			v3_s3   <= 1'b0;
			v4_s4   <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (rdy1) v1_s1 <= in_valid;
			if (rdy2) v2_s2 <= v1_s1;
			if (rdy3) v3_s3 <= v2_s2;
			if (rdy4) v4_s4 <= v3_s3;
			if (out_acc) begin
				phase_q <= flags_s4.chroma && !phase_q;
			end
		end
	end

	// Stage 1 logic: luma numerator and 2x2 block averages
	logic [21:0] luma_num;
	logic [10:0] sum_r, sum_g, sum_b;

	assign luma_num = 22'(rgb2yuv_pkg::Y_R) * 22'(r_s1)
	                + 22'(rgb2yuv_pkg::Y_G) * 22'(g_s1)
	                + 22'(rgb2yuv_pkg::Y_B) * 22'(b_s1)
	                + 22'(rgb2yuv_pkg::ROUND_BIAS);
	assign sum_r = {2'b0, line_rd_s1[26:18]} + 11'(held_s1[23:16]) + 11'(r_s1) + 11'd2;
	assign sum_g = {2'b0, line_rd_s1[17:9]} + 11'(held_s1[15:8]) + 11'(g_s1) + 11'd2;
	assign sum_b = {2'b0, line_rd_s1[8:0]} + 11'(held_s1[7:0]) + 11'(b_s1) + 11'd2;

	// Stage 2 logic: luma divide, chroma numerators as sign and magnitude
	logic [44:0]        luma_prod;
	logic signed [23:0] ar_x, ag_x, ab_x, u_num, v_num;
	logic [23:0]        u_abs, v_abs;

	assign luma_prod = 45'(luma_num_s2) * 45'(rgb2yuv_pkg::RECIP_M);
	assign ar_x  = 24'($signed({1'b0, ar_s2}));
	assign ag_x  = 24'($signed({1'b0, ag_s2}));
	assign ab_x  = 24'($signed({1'b0, ab_s2}));
	assign u_num = 24'(rgb2yuv_pkg::CB_R) * ar_x + 24'(rgb2yuv_pkg::CB_G) * ag_x
	             + 24'(rgb2yuv_pkg::CB_B) * ab_x + 24'(rgb2yuv_pkg::ROUND_BIAS_S);
	assign v_num = 24'(rgb2yuv_pkg::CR_R) * ar_x + 24'(rgb2yuv_pkg::CR_G) * ag_x
	             + 24'(rgb2yuv_pkg::CR_B) * ab_x + 24'(rgb2yuv_pkg::ROUND_BIAS_S);
	assign u_abs = u_num[23] ? 24'(-u_num) : 24'(u_num);
	assign v_abs = v_num[23] ? 24'(-v_num) : 24'(v_num);

	// Stage 3 logic: chroma divide, truncating toward zero.
	// Quotients stay within 0..112, so the offsets land inside 16..240.
	logic [43:0] u_prod, v_prod;
	logic [7:0]  uq, vq;

	assign u_prod = 44'(u_mag_s3) * 44'(rgb2yuv_pkg::RECIP_M);
	assign v_prod = 44'(v_mag_s3) * 44'(rgb2yuv_pkg::RECIP_M);
	assign uq     = u_prod[43:rgb2yuv_pkg::RECIP_SHIFT];
	assign vq     = v_prod[43:rgb2yuv_pkg::RECIP_SHIFT];

	// Stage payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			r_s1     <= red;
			g_s1     <= green;
			b_s1     <= blue;
			held_s1  <= held_q;
			flags_s1 <= '{chroma: odd_col && odd_row, frame_end: last_pix};
		end
		if (rdy2 && v1_s1) begin
			luma_num_s2 <= luma_num;
			ar_s2       <= sum_r[9:2];
			ag_s2       <= sum_g[9:2];
			ab_s2       <= sum_b[9:2];
			flags_s2    <= flags_s1;
		end
		if (rdy3 && v2_s2) begin
			// luma quotient is at most 219
			yq_s3    <= luma_prod[43:rgb2yuv_pkg::RECIP_SHIFT];
			u_mag_s3 <= u_abs[20:0];
			v_mag_s3 <= v_abs[20:0];
			u_neg_s3 <= u_num[23];
			v_neg_s3 <= v_num[23];
			flags_s3 <= flags_s2;
		end
		if (rdy4 && v3_s3) begin
			y_s4     <= yq_s3 + rgb2yuv_pkg::LUMA_OFS;
			cb_s4    <= u_neg_s3 ? rgb2yuv_pkg::CHROMA_OFS - uq : rgb2yuv_pkg::CHROMA_OFS + uq;
			cr_s4    <= v_neg_s3 ? rgb2yuv_pkg::CHROMA_OFS - vq : rgb2yuv_pkg::CHROMA_OFS + vq;
			flags_s4 <= flags_s3;
		end
	end

	// Output: luma item first, then the chroma item when the pixel has one
	assign out_valid   = v4_s4;
	assign kind        = phase_q ? rgb2yuv_pkg::KIND_CHROMA : rgb2yuv_pkg::KIND_LUMA;
	assign luma        = phase_q ? 8'd0 : y_s4;
	assign chroma_blue = phase_q ? cb_s4 : 8'd0;
	assign chroma_red  = phase_q ? cr_s4 : 8'd0;
	assign last        = phase_q || !flags_s4.chroma;
	assign frame_end   = flags_s4.frame_end;

endmodule

`default_nettype wire

// ----- rtl/core/rgb2yuv_checker.sv -----
// Port-level checks for the RGB to 4:2:0 YCbCr converter, bound to its top
// level. Depends on rgb2yuv_pkg.
`default_nettype none

module rgb2yuv_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       kind,
	input wire logic [7:0] luma,
	input wire logic [7:0] chroma_blue,
	input wire logic [7:0] chroma_red,
	input wire logic       last,
	input wire logic       frame_end
);

	// Hold a stalled output item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid
			&& $stable({kind, luma, chroma_blue, chroma_red, last, frame_end}))
		else $error("stalled output item changed");

	// Follow a luma item that is not last with its chroma item
	a_chroma_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && kind == rgb2yuv_pkg::KIND_LUMA && !last
		|=> out_valid && kind == rgb2yuv_pkg::KIND_CHROMA)
		else $error("chroma item missing after luma item");

	// Emit a chroma item only right after its luma item, or while stalled
	a_chroma_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == rgb2yuv_pkg::KIND_CHROMA
		|-> $past(out_valid && ((kind == rgb2yuv_pkg::KIND_LUMA && !last && !out_stall)
			|| (kind == rgb2yuv_pkg::KIND_CHROMA && out_stall))))
		else $error("chroma item without preceding luma item");

	// Keep field ranges consistent with the item kind
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == rgb2yuv_pkg::KIND_LUMA
			&& chroma_blue == 8'd0 && chroma_red == 8'd0 && luma >= 8'd16 && luma <= 8'd235)
		|| (kind == rgb2yuv_pkg::KIND_CHROMA && last && luma == 8'd0
			&& chroma_blue >= 8'd16 && chroma_blue <= 8'd240
			&& chroma_red >= 8'd16 && chroma_red <= 8'd240))
		else $error("output fields out of range for item kind");

endmodule

bind rgba_to_i420_bt709_converter rgb2yuv_checker u_checker (.*);

`default_nettype wire
